FILE: sv/assert_macros.svh
// assertion helpers used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on clk, off while arst_n is low
`define MMKI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check, evaluated also during reset
`define MMKI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/mmki_pkg.sv
// ----------------------------------------------------------------------------
// mmki_pkg
// Shared constants and permutation tables for the key matrix inverse unit.
// ----------------------------------------------------------------------------
package mmki_pkg;

	localparam int MAX_ORDER = 4;
	localparam int KEY_DEPTH = MAX_ORDER * MAX_ORDER;

	localparam logic [7:0] MODULUS_RESET = 8'd26;
	localparam logic [2:0] ORDER_RESET   = 3'd3;

	typedef enum logic [1:0] {
		REG_MODULUS = 2'd0,
		REG_ORDER   = 2'd1
	} reg_index_t;

	// one nibble per row, row 0 in the top nibble, holding the column index
	localparam logic [15:0] PERM4_WORD [24] = '{
		16'h0123, 16'h0132, 16'h0213, 16'h0231, 16'h0312, 16'h0321,
		16'h1023, 16'h1032, 16'h1203, 16'h1230, 16'h1302, 16'h1320,
		16'h2013, 16'h2031, 16'h2103, 16'h2130, 16'h2301, 16'h2310,
		16'h3012, 16'h3021, 16'h3102, 16'h3120, 16'h3201, 16'h3210
	};
	localparam logic [0:23] PERM4_ODD = 24'b011001_100110_011001_100110;

	localparam logic [15:0] PERM3_WORD [6] = '{
		16'h0120, 16'h0210, 16'h1020, 16'h1200, 16'h2010, 16'h2100
	};
	localparam logic [0:5] PERM3_ODD = 6'b011001;

	localparam logic [15:0] PERM2_WORD [2] = '{16'h0100, 16'h1000};
	localparam logic [0:1]  PERM2_ODD  = 2'b01;

	function automatic logic [15:0] perm_word(input logic [2:0] ksize, input logic [4:0] p);
		logic [15:0] w;
		w = 16'h0000;
		case (ksize)
			3'd4: w = PERM4_WORD[p];
			3'd3: w = PERM3_WORD[p[2:0]];
			3'd2: w = PERM2_WORD[p[0]];
			default: w = 16'h0000;
		endcase
		return w;
	endfunction

	function automatic logic perm_odd(input logic [2:0] ksize, input logic [4:0] p);
		logic o;
		o = 1'b0;
		case (ksize)
			3'd4: o = PERM4_ODD[p];
			3'd3: o = PERM3_ODD[p[2:0]];
			3'd2: o = PERM2_ODD[p[0]];
			default: o = 1'b0;
		endcase
		return o;
	endfunction

	function automatic logic [4:0] perm_count(input logic [2:0] ksize);
		logic [4:0] c;
		c = 5'd1;
		case (ksize)
			3'd4: c = 5'd24;
			3'd3: c = 5'd6;
			3'd2: c = 5'd2;
			default: c = 5'd1;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/mmki_mulmod.sv
// ----------------------------------------------------------------------------
// mmki_mulmod
// Bit-serial modular multiplier: (a * b) mod m, a below m, one bit of b a cycle.
// ----------------------------------------------------------------------------
module mmki_mulmod import mmki_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] a,
	input  logic [7:0] b,
	input  logic [7:0] m,
	output logic       done,
	output logic [7:0] res
);

	logic       busy_q;
	logic       done_q;
	logic [2:0] bit_q;
	logic [7:0] acc_q;
	logic [7:0] a_q;
	logic [7:0] b_q;
	logic [7:0] m_q;
	logic [9:0] sum_w;
	logic [9:0] red_w;

	always_comb begin
		sum_w = {1'b0, acc_q, 1'b0} + (b_q[bit_q] ? {2'b00, a_q} : 10'd0);
		if (sum_w >= {1'b0, m_q, 1'b0}) begin
			red_w = sum_w - {1'b0, m_q, 1'b0};
		end else if (sum_w >= {2'b00, m_q}) begin
			red_w = sum_w - {2'b00, m_q};
		end else begin
			red_w = sum_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= 3'd7;
			end else if (busy_q) begin
				bit_q <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= 8'd0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= red_w[7:0];
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

FILE: sv/modular_matrix_key_inverse_unit.sv
// ----------------------------------------------------------------------------
// modular_matrix_key_inverse_unit
// Loads a square key matrix and returns its inverse modulo the alphabet size.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / key_entry): one key entry per item, in
// row-major order. An entry is taken every cycle while in_stall is low; the
// item that completes n*n entries, n being the order clamped to 1..4, starts
// the computation and in_stall stays high until the last result has been taken.
// Output channel (out_valid / out_stall): either order*order inverse entries
// in row-major order with last_result on the final one, or one item with
// invertible low, zero entry and last_result high. A result waits in the
// output register while out_stall is high, and the next one is not started.
// Operation: every product runs through one bit-serial modular multiplier.
// The determinant is summed over all permutations of the key, the search for
// its inverse tries each candidate below the modulus, and each result is the
// cofactor from a minor determinant, scaled by that inverse.
// Reset: modulus 26, order 3, load count cleared, block ready for entries.
// Configuration writes take effect at once; change them only while no
// computation is running.
// ----------------------------------------------------------------------------
module modular_matrix_key_inverse_unit import mmki_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] key_entry,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] inverse_entry,
	output logic       invertible,
	output logic       last_result
);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_TERM,
		ST_ROW,
		ST_MUL,
		ST_ACC,
		ST_INV,
		ST_ADJ,
		ST_SCALE,
		ST_OUT
	} state_t;

	state_t     state_q;
	logic [7:0] modulus_q;
	logic [2:0] order_q;
	logic [3:0] load_cnt_q;
	logic [7:0] key_store_q [KEY_DEPTH];
	logic       minor_q;
	logic [1:0] out_i_q;
	logic [1:0] out_j_q;
	logic [4:0] perm_q;
	logic [2:0] row_q;
	logic [7:0] prod_q;
	logic [7:0] acc_q;
	logic [7:0] det_q;
	logic [7:0] dinv_q;
	logic [7:0] t_q;
	logic [7:0] r_q;
	logic       out_valid_q;
	logic [7:0] out_entry_q;
	logic       out_inv_q;
	logic       out_last_q;

	logic [7:0]  m_w;
	logic [2:0]  n_w;
	logic [2:0]  ksize_w;
	logic [15:0] pword_w;
	logic        podd_w;
	logic [4:0]  pcount_w;
	logic [1:0]  t_row_w;
	logic [1:0]  pcol_w;
	logic [1:0]  rmap_w;
	logic [1:0]  cmap_w;
	logic [4:0]  addr_w;
	logic [7:0]  key_w;
	logic [7:0]  operand_w;
	logic [8:0]  accsum_w;
	logic [7:0]  accnext_w;
	logic [8:0]  rsum_w;
	logic [7:0]  rnext_w;
	logic [7:0]  adj_w;
	logic [4:0]  nsq_w;
	logic [4:0]  cnt_next_w;
	logic        mm_start;
	logic [7:0]  mm_a;
	logic [7:0]  mm_b;
	logic        mm_done;
	logic [7:0]  mm_res;
	logic        last_pos_w;

	always_comb begin
		m_w = (modulus_q < 8'd2) ? 8'd2 : modulus_q;
		if (order_q == 3'd0) begin
			n_w = 3'd1;
		end else if (order_q > 3'(MAX_ORDER)) begin
			n_w = 3'(MAX_ORDER);
		end else begin
			n_w = order_q;
		end
		ksize_w  = minor_q ? (n_w - 3'd1) : n_w;
		pword_w  = perm_word(ksize_w, perm_q);
		podd_w   = perm_odd(ksize_w, perm_q);
		pcount_w = perm_count(ksize_w);
		t_row_w  = row_q[1:0];
		pcol_w   = pword_w[{~t_row_w, 2'b00} +: 2];
		rmap_w   = (minor_q && t_row_w >= out_j_q) ? t_row_w + 2'd1 : t_row_w;
		cmap_w   = (minor_q && pcol_w >= out_i_q) ? pcol_w + 2'd1 : pcol_w;
		addr_w   = 5'(rmap_w) * 5'(n_w) + 5'(cmap_w);
		key_w    = key_store_q[addr_w[3:0]];

		operand_w = podd_w ? (m_w - prod_q) : prod_q;
		accsum_w  = {1'b0, acc_q} + {1'b0, operand_w};
		accnext_w = (accsum_w >= {1'b0, m_w}) ? 8'(accsum_w - {1'b0, m_w}) : accsum_w[7:0];

		rsum_w  = {1'b0, r_q} + {1'b0, det_q};
		rnext_w = (rsum_w >= {1'b0, m_w}) ? 8'(rsum_w - {1'b0, m_w}) : rsum_w[7:0];

		adj_w = ((out_i_q[0] ^ out_j_q[0]) && acc_q != 8'd0) ? (m_w - acc_q) : acc_q;

		nsq_w      = 5'(n_w) * 5'(n_w);
		cnt_next_w = {1'b0, load_cnt_q} + 5'd1;
		last_pos_w = ({1'b0, out_i_q} == n_w - 3'd1) && ({1'b0, out_j_q} == n_w - 3'd1);

		mm_start = 1'b0;
		mm_a     = prod_q;
		mm_b     = key_w;
		case (state_q)
			ST_ROW: mm_start = (row_q != ksize_w);
			ST_ADJ: begin
				mm_start = 1'b1;
				mm_a     = adj_w;
				mm_b     = dinv_q;
			end
			default: mm_start = 1'b0;
		endcase
	end

	mmki_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (m_w),
		.done   (mm_done),
		.res    (mm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			order_q   <= ORDER_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_data;
				REG_ORDER:   order_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_valid) begin
			key_store_q[load_cnt_q] <= key_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= 4'd0;
			minor_q     <= 1'b0;
			out_i_q     <= 2'd0;
			out_j_q     <= 2'd0;
			perm_q      <= 5'd0;
			row_q       <= 3'd0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			det_q       <= 8'd0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (cnt_next_w >= nsq_w) begin
							load_cnt_q <= 4'd0;
							minor_q    <= 1'b0;
							acc_q      <= 8'd0;
							perm_q     <= 5'd0;
							state_q    <= ST_TERM;
						end else begin
							load_cnt_q <= cnt_next_w[3:0];
						end
					end
				end
				ST_TERM: begin
					prod_q  <= 8'd1;
					row_q   <= 3'd0;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					state_q <= (row_q == ksize_w) ? ST_ACC : ST_MUL;
				end
				ST_MUL: begin
					if (mm_done) begin
						prod_q  <= mm_res;
						row_q   <= row_q + 3'd1;
						state_q <= ST_ROW;
					end
				end
				ST_ACC: begin
					acc_q <= accnext_w;
					if (perm_q == pcount_w - 5'd1) begin
						if (!minor_q) begin
							det_q   <= accnext_w;
							r_q     <= accnext_w;
							t_q     <= 8'd1;
							state_q <= ST_INV;
						end else begin
							state_q <= ST_ADJ;
						end
					end else begin
						perm_q  <= perm_q + 5'd1;
						state_q <= ST_TERM;
					end
				end
				ST_INV: begin
					if (r_q == 8'd1) begin
						dinv_q  <= t_q;
						minor_q <= 1'b1;
						out_i_q <= 2'd0;
						out_j_q <= 2'd0;
						acc_q   <= 8'd0;
						perm_q  <= 5'd0;
						state_q <= ST_TERM;
					end else if (t_q == m_w - 8'd1) begin
						out_entry_q <= 8'd0;
						out_inv_q   <= 1'b0;
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end else begin
						t_q <= t_q + 8'd1;
						r_q <= rnext_w;
					end
				end
				ST_ADJ: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (mm_done) begin
						out_entry_q <= mm_res;
						out_inv_q   <= 1'b1;
						out_last_q  <= last_pos_w;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_LOAD;
						end else begin
							if ({1'b0, out_j_q} == n_w - 3'd1) begin
								out_j_q <= 2'd0;
								out_i_q <= out_i_q + 2'd1;
							end else begin
								out_j_q <= out_j_q + 2'd1;
							end
							acc_q   <= 8'd0;
							perm_q  <= 5'd0;
							state_q <= ST_TERM;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign in_stall      = (state_q != ST_LOAD);
	assign out_valid     = out_valid_q;
	assign inverse_entry = out_entry_q;
	assign invertible    = out_inv_q;
	assign last_result   = out_last_q;

endmodule

FILE: sv/mmki_checker.sv
// ----------------------------------------------------------------------------
// mmki_port_props
// Port-level checks for the key matrix inverse unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmki_port_props import mmki_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] inverse_entry,
	input logic       invertible,
	input logic       last_result
);

	// a stalled result item holds
	`MMKI_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(inverse_entry) && $stable(last_result), "stalled result changed")

	// a failed key gives one zero item that closes the run
	`MMKI_ASSERT(a_fail_item, out_valid && !invertible |-> last_result && inverse_entry == 8'd0, "bad not-invertible item")

	// no entries are taken while a result is pending
	`MMKI_ASSERT(a_busy_out, out_valid |-> in_stall, "input open during output")

	// after the final item is taken the block reopens for entries
	`MMKI_ASSERT(a_reopen, out_valid && last_result && !out_stall |=> !in_stall && !out_valid, "block did not reopen")

endmodule

bind modular_matrix_key_inverse_unit mmki_port_props u_mmki_port_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.inverse_entry (inverse_entry),
	.invertible    (invertible),
	.last_result   (last_result)
);

FILE: verif/mmki_checker.sv
// ----------------------------------------------------------------------------
// mmki_checker
// Watches the configuration port and both channels of the key matrix inverse
// unit, predicts every inverse entry from the accepted key entries and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module mmki_checker import mmki_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] key_entry,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] inverse_entry,
	input  logic       invertible,
	input  logic       last_result,
	output int         fail_count,
	output int         pending,
	output int         key_runs,
	output int         singular_runs
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] entry;
		logic       inv;
		logic       last;
	} inv_result_t;

	inv_result_t inverse_q[$];
	logic [7:0]  mod_reg;
	logic [2:0]  order_reg;
	logic [7:0]  key_mem [KEY_DEPTH];
	int unsigned entries_loaded;

	function automatic int unsigned det_mod(input int unsigned a [4][4], input int k,
			input int unsigned m);
		int unsigned s [4][4];
		int unsigned acc;
		int unsigned term;
		int t;
		acc = 0;
		if (k == 0) return 1 % m;
		if (k == 1) return a[0][0] % m;
		for (int j = 0; j < k; j++) begin
			for (int r = 1; r < k; r++) begin
				t = 0;
				for (int c = 0; c < k; c++) begin
					if (c != j) begin
						s[r-1][t] = a[r][c];
						t++;
					end
				end
			end
			term = (a[0][j] * det_mod(s, k - 1, m)) % m;
			acc = (j % 2 == 0) ? (acc + term) % m : (acc + m - term) % m;
		end
		return acc;
	endfunction

	task automatic load_key_entry(input logic [7:0] v);
		int unsigned n;
		int unsigned m;
		int unsigned mat [4][4];
		int unsigned sub [4][4];
		int unsigned det;
		int unsigned dinv;
		int unsigned a;
		int rr;
		int cc;
		inv_result_t res;
		n = (order_reg < 1) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
		m = (mod_reg < 2) ? 2 : mod_reg;
		if (entries_loaded < KEY_DEPTH) key_mem[entries_loaded] = v;
		entries_loaded++;
		if (entries_loaded < n * n) return;
		entries_loaded = 0;
		key_runs++;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				mat[i][j] = (i < n && j < n) ? key_mem[i*n+j] % m : 0;
		det = det_mod(mat, n, m);
		dinv = 0;
		for (int t = 1; t < m; t++) begin
			if ((det * t) % m == 1) begin
				dinv = t;
				break;
			end
		end
		if (dinv == 0) begin
			singular_runs++;
			res.entry = 8'd0;
			res.inv = 1'b0;
			res.last = 1'b1;
			inverse_q.insert(inverse_q.size(), res);
			return;
		end
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				// minor drops row j and column i
				rr = 0;
				for (int r = 0; r < n; r++) begin
					if (r != j) begin
						cc = 0;
						for (int c = 0; c < n; c++) begin
							if (c != i) begin
								sub[rr][cc] = mat[r][c];
								cc++;
							end
						end
						rr++;
					end
				end
				a = det_mod(sub, n - 1, m);
				if ((i + j) % 2 != 0) a = (m - a) % m;
				res.entry = 8'((a * dinv) % m);
				res.inv = 1'b1;
				res.last = (i == n - 1 && j == n - 1);
				inverse_q.insert(inverse_q.size(), res);
			end
		end
	endtask

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp_v);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp_v);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		inv_result_t e;
		if (!arst_n) begin
			mod_reg = MODULUS_RESET;
			order_reg = ORDER_RESET;
			entries_loaded = 0;
			inverse_q.delete();
			fail_count = 0;
			key_runs = 0;
			singular_runs = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (inverse_q.size() == 0) begin
					report("unexpected item, entry", inverse_entry, 8'd0);
				end else begin
					e = inverse_q.pop_front();
					if (inverse_entry !== e.entry) report("inverse_entry", inverse_entry, e.entry);
					if (invertible !== e.inv)
						report("invertible", {7'd0, invertible}, {7'd0, e.inv});
					if (last_result !== e.last)
						report("last_result", {7'd0, last_result}, {7'd0, e.last});
				end
			end
			if (in_valid && !in_stall) load_key_entry(key_entry);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MODULUS: mod_reg = cfg_data;
					REG_ORDER:   order_reg = cfg_data[2:0];
					default: ;
				endcase
			end
		end
		pending = inverse_q.size();
	end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives key entries and register settings into the key matrix inverse unit
// under random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top import mmki_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] key_entry = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] inverse_entry;
	logic       invertible;
	logic       last_result;
	int         fail_count;
	int         pending;
	int         key_runs;
	int         singular_runs;
	bit         quiet = 1'b0;
	int         stall_left = 0;
	int         sent = 0;
	int         cur_order = 3;

	always #4 clk = ~clk;

	modular_matrix_key_inverse_unit u_dut (.*);

	mmki_checker u_chk (.*);

	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 15);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_key(input logic [7:0] v);
		bit ok;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_entry <= v;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		sent++;
	endtask

	// wait until every predicted result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [7:0] v);
		drain();
		repeat (50) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_ORDER) cur_order = (v[2:0] < 1) ? 1 : (v[2:0] > 4) ? 4 : v[2:0];
	endtask

	task automatic send_key_set(input int kind);
		for (int i = 0; i < cur_order * cur_order; i++) begin
			case (kind)
				0: send_key(8'($urandom));
				1: send_key((i % (cur_order + 1) == 0) ? 8'd1 : 8'd0);
				default: send_key(8'($urandom_range(0, 3)));
			endcase
		end
	endtask

	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset order 3, modulus 26
		send_key_set(1);
		send_key_set(0);
		write_reg(REG_ORDER, 8'd1);
		send_key(8'd0);
		send_key(8'd1);
		send_key(8'd25);
		send_key(8'd255);
		send_key(8'd13);
		// modulus below two behaves as two
		write_reg(REG_MODULUS, 8'd0);
		send_key(8'd3);
		write_reg(REG_MODULUS, 8'd1);
		send_key(8'd2);
		// order zero and above the maximum
		write_reg(REG_MODULUS, 8'd255);
		write_reg(REG_ORDER, 8'd0);
		send_key(8'd254);
		write_reg(REG_ORDER, 8'd7);
		send_key_set(1);
		// unused register index is ignored
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= reg_index_t'(2'd3);
		cfg_data <= 8'h5a;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		// order change in the middle of a load
		write_reg(REG_ORDER, 8'd3);
		send_key(8'd7);
		send_key(8'd200);
		write_reg(REG_ORDER, 8'd1);
		send_key(8'd11);
		write_reg(REG_MODULUS, 8'd2);
		write_reg(REG_ORDER, 8'd2);
		send_key_set(0);
		// everything drains before the random part
		drain();
		while (sent < 390) begin
			case ($urandom_range(0, 5))
				0: write_reg(REG_MODULUS, 8'd26);
				1: write_reg(REG_MODULUS, 8'($urandom_range(0, 255)));
				2: write_reg(REG_MODULUS, 8'($urandom_range(2, 30)));
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0: write_reg(REG_ORDER, 8'd4);
				1, 2, 3: write_reg(REG_ORDER, 8'd1);
				4: write_reg(REG_ORDER, 8'($urandom));
				5: ;
				default: write_reg(REG_ORDER, 8'($urandom_range(2, 3)));
			endcase
			if (sent > 330) quiet = 1'b1;
			repeat ((cur_order == 4) ? 1 : $urandom_range(1, 5))
				send_key_set($urandom_range(0, 4) == 0 ? 2 : 0);
		end
		drain();
		repeat (100) @(posedge clk);
		$display("covered %0d key entries in %0d key loads, %0d of them singular",
			sent, key_runs, singular_runs);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/mmki_pkg.sv
sv/mmki_mulmod.sv
sv/modular_matrix_key_inverse_unit.sv
sv/mmki_checker.sv
verif/mmki_checker.sv
verif/tb_top.sv
